/* hw/rtl/tsmi_pkg.sv */
// ---------------------------------------------------------------------------
// tsmi_pkg: shared types and constants for the timestamp tag marker inserter
// Operation codes, the queued transaction record, checksum word constants.
// ---------------------------------------------------------------------------
package tsmi_pkg;

  // Default marker list capacity
  localparam int MAX_MARKERS_DEF = 64;

  // Front/back decoupling queue depth
  localparam int QUEUE_DEPTH = 2;

  // Width of the partial checksum sum carried from front to back
  localparam int CK_SUM_W = 18;

  // Trailer half-words touched by the tag (RFC 1624 incremental update)
  localparam logic [15:0] CK_ODD_OLD_HI  = 16'h221d;
  localparam logic [15:0] CK_ODD_NEW_HI  = 16'h231d;
  localparam logic [15:0] CK_ODD_LO      = 16'h6100;
  localparam logic [15:0] CK_EVEN_OLD    = 16'h0022;
  localparam logic [15:0] CK_EVEN_NEW_LO = 16'h0023;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_START  = 2'd2,
    OP_PACKET = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [31:0]         marker_value;
    logic                has_ck;
    logic                odd;
    logic [15:0]         old_ck;
    logic [CK_SUM_W-1:0] ck_base;   // ~old + fixed words, tag id still missing
  } item_t;

endpackage

/* hw/rtl/tsmi_front.sv */
// ---------------------------------------------------------------------------
// tsmi_front: input classifier
// Decodes the function code and folds the id-independent part of the
// incremental checksum update into a partial sum.
// ---------------------------------------------------------------------------
module tsmi_front (
  input  logic [1:0]      func,
  input  logic [31:0]     marker_value,
  input  logic            has_l4_checksum,
  input  logic [15:0]     old_checksum,
  input  logic            odd_length,
  output tsmi_pkg::item_t item
);
  import tsmi_pkg::*;

  localparam logic [CK_SUM_W-17:0] CK_PAD = '0;

  // Odd length: ~m0 + m0' + ~m1 + (m1' without the id byte)
  localparam logic [CK_SUM_W-1:0] ODD_K =
      {CK_PAD, ~CK_ODD_OLD_HI} + {CK_PAD, CK_ODD_NEW_HI} +
      {CK_PAD, ~CK_ODD_LO} + {CK_PAD, CK_ODD_LO};
  // Even length: ~m + (m' without the id byte)
  localparam logic [CK_SUM_W-1:0] EVEN_K =
      {CK_PAD, ~CK_EVEN_OLD} + {CK_PAD, CK_EVEN_NEW_LO};

  logic [CK_SUM_W-1:0] inv_old;

  assign inv_old = {CK_PAD, ~old_checksum};

  always_comb begin
    item.op           = op_t'(func);
    item.marker_value = marker_value;
    item.has_ck       = has_l4_checksum;
    item.odd          = odd_length;
    item.old_ck       = old_checksum;
    item.ck_base      = inv_old + (odd_length ? ODD_K : EVEN_K);
  end

endmodule

/* hw/rtl/tsmi_queue.sv */
// ---------------------------------------------------------------------------
// tsmi_queue: front-to-back transaction queue
// Small circular buffer; push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
module tsmi_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tsmi_pkg::item_t push_item,
  output logic            full,
  output logic            head_valid,
  input  logic            pop,
  output tsmi_pkg::item_t head_item
);
  import tsmi_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow push");

endmodule

/* hw/rtl/tsmi_back.sv */
// ---------------------------------------------------------------------------
// tsmi_back: execution side
// Marker list as a delta memory, packet counter, tag arming and the result
// register toward the output channel.
// ---------------------------------------------------------------------------
module tsmi_back #(
  parameter int MAX_MARKERS = tsmi_pkg::MAX_MARKERS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [31:0]     cfg_data,
  input  logic            head_valid,
  input  tsmi_pkg::item_t head_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            tagged_res,
  output logic [7:0]      tag_id,
  output logic [15:0]     new_checksum,
  output logic            load_overflow
);
  import tsmi_pkg::*;

  localparam int FILL_W = $clog2(MAX_MARKERS + 1);
  localparam int IDX_W  = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;

  // delta_mem[i] = marker[i+1] - marker[i]; closing delta comes from registers
  logic [31:0]       delta_mem [MAX_MARKERS];
  logic [31:0]       rd_delta;

  logic [31:0]       repeat_interval;
  logic [FILL_W-1:0] fill, fill_next;
  logic [IDX_W-1:0]  index, index_next;
  logic [63:0]       packet_count, packet_count_next;
  logic [63:0]       next_tag, next_tag_next;
  logic [7:0]        cur_id, cur_id_next;
  logic [31:0]       first_marker, first_marker_next;
  logic [31:0]       last_marker, last_marker_next;

  logic              hit;
  logic              list_full;
  logic [FILL_W-1:0] idx_inc;
  logic [31:0]       closing;
  logic [31:0]       delta;
  logic [63:0]       tag_advance;
  logic [CK_SUM_W-1:0] ck_sum;
  logic [16:0]       ck_fold1;
  logic [15:0]       ck_fold2;
  logic [15:0]       tag_ck;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [31:0]       wdata;

  logic              res_tagged;
  logic [7:0]        res_id;
  logic [15:0]       res_ck;
  logic              res_ovf;

  assign cfg_ready = 1'b1;
  assign pop       = head_valid && (!out_valid || !out_stall);

  assign hit       = (packet_count == next_tag);
  assign list_full = (fill == FILL_W'(MAX_MARKERS));
  assign idx_inc   = FILL_W'(index) + 1'b1;
  assign closing   = repeat_interval - last_marker + first_marker;
  assign delta     = (idx_inc < fill) ? rd_delta : closing;
  assign tag_advance = (fill != '0) ? next_tag + {32'd0, delta} : next_tag + {64{1'b1}};

  // Finish the incremental update: add the id byte, fold carries, complement
  assign ck_sum   = head_item.ck_base + (head_item.odd ? CK_SUM_W'(cur_id)
                                                        : CK_SUM_W'({cur_id, 8'h00}));
  assign ck_fold1 = {1'b0, ck_sum[15:0]} + 17'(ck_sum[CK_SUM_W-1:16]);
  assign ck_fold2 = ck_fold1[15:0] + 16'(ck_fold1[16]);
  assign tag_ck   = ~ck_fold2;

  assign waddr = IDX_W'(fill - 1'b1);
  assign wdata = head_item.marker_value - last_marker;

  always_comb begin
    fill_next         = fill;
    index_next        = index;
    packet_count_next = packet_count;
    next_tag_next     = next_tag;
    cur_id_next       = cur_id;
    first_marker_next = first_marker;
    last_marker_next  = last_marker;
    we                = 1'b0;
    res_tagged        = 1'b0;
    res_id            = '0;
    res_ck            = '0;
    res_ovf           = 1'b0;
    if (pop) begin
      unique case (head_item.op)
        OP_CLEAR: begin
          fill_next  = '0;
          index_next = '0;
        end
        OP_APPEND: begin
          if (list_full) begin
            res_ovf = 1'b1;
          end else begin
            fill_next        = fill + 1'b1;
            last_marker_next = head_item.marker_value;
            if (fill == '0) begin
              first_marker_next = head_item.marker_value;
            end else begin
              we = 1'b1;
            end
          end
        end
        OP_START: begin
          index_next    = '0;
          next_tag_next = (fill != '0) ? packet_count + {32'd0, first_marker}
                                       : packet_count + {64{1'b1}};
        end
        OP_PACKET: begin
          res_ck = head_item.old_ck;
          if (hit) begin
            res_tagged    = 1'b1;
            res_id        = cur_id;
            cur_id_next   = cur_id + 1'b1;
            next_tag_next = tag_advance;
            index_next    = (idx_inc < fill) ? IDX_W'(idx_inc) : '0;
            if (head_item.has_ck) begin
              res_ck = tag_ck;
            end
          end
          packet_count_next = packet_count + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Delta memory: one write port, one registered read at the next index
  always_ff @(posedge clk) begin
    if (we) begin
      delta_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == index_next)) begin
      rd_delta <= wdata;
    end else begin
      rd_delta <= delta_mem[index_next];
    end
  end

  always_ff @(posedge clk) begin
    first_marker <= first_marker_next;
    last_marker  <= last_marker_next;
    if (pop) begin
      tagged_res    <= res_tagged;
      tag_id        <= res_id;
      new_checksum  <= res_ck;
      load_overflow <= res_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_interval <= '0;
      fill            <= '0;
      index           <= '0;
      packet_count    <= '0;
      next_tag        <= {64{1'b1}};
      cur_id          <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        repeat_interval <= cfg_data;
      end
      fill         <= fill_next;
      index        <= index_next;
      packet_count <= packet_count_next;
      next_tag     <= next_tag_next;
      cur_id       <= cur_id_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(MAX_MARKERS))
    else $error("marker fill beyond capacity");

  a_index_in_list: assert property (@(posedge clk) disable iff (rst)
    (FILL_W'(index) < fill) || (index == '0))
    else $error("marker index outside list");

  a_id_advance: assert property (@(posedge clk) disable iff (rst)
    (pop && head_item.op == OP_PACKET && hit) |=> (cur_id == $past(cur_id) + 1'b1))
    else $error("tag id did not advance on hit");

  a_ovf_untagged: assert property (@(posedge clk) disable iff (rst)
    (out_valid && load_overflow) |-> !tagged_res)
    else $error("overflow flagged on a tagged result");

endmodule

/* hw/rtl/timestamp_tag_marker_insert.sv */
// ---------------------------------------------------------------------------
// timestamp_tag_marker_insert: packet tagger with incremental checksum update
// Tags packets at marker positions of a repeating interval and patches the
// L4 checksum for the trailer change.
// ---------------------------------------------------------------------------
// Throughput: one transaction per cycle sustained while the output is not
//   stalled; the back-end execute step is a 64-bit compare plus delta add.
// Path: an accepted input is written into the queue, then executed into the
//   result register, from which it is offered; a held output delays execute.
// Reset: synchronous; clears fill, index, packet count, tag id, interval and
//   arms the next tag at all ones. The marker delta memory is not cleared.
module timestamp_tag_marker_insert #(
  parameter int MAX_MARKERS = tsmi_pkg::MAX_MARKERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: repeat_interval
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // input transactions
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] marker_value,
  input  logic        has_l4_checksum,
  input  logic [15:0] old_checksum,
  input  logic        odd_length,
  // result transactions
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tagged_res,
  output logic [7:0]  tag_id,
  output logic [15:0] new_checksum,
  output logic        load_overflow
);
  import tsmi_pkg::*;

  item_t front_item;
  item_t head_item;
  logic  q_full;
  logic  q_push;
  logic  head_valid;
  logic  pop;

  // Front end: decode func and pre-sum the fixed checksum words
  tsmi_front u_front (
    .func            (func),
    .marker_value    (marker_value),
    .has_l4_checksum (has_l4_checksum),
    .old_checksum    (old_checksum),
    .odd_length      (odd_length),
    .item            (front_item)
  );

  // Input stalls only when the queue is full; the back end drains it
  // whenever the result register is free or being taken.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  tsmi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (front_item),
    .full       (q_full),
    .head_valid (head_valid),
    .pop        (pop),
    .head_item  (head_item)
  );

  // Back end: marker list, packet count, tag arming, result register
  tsmi_back #(
    .MAX_MARKERS (MAX_MARKERS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .tagged_res    (tagged_res),
    .tag_id        (tag_id),
    .new_checksum  (new_checksum),
    .load_overflow (load_overflow)
  );

endmodule

/* sim/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for timestamp_tag_marker_insert
// Drives marker loads, run starts and packet transactions, predicts tag hits,
// tag ids and patched L4 checksums in a local model, and compares every
// result transaction in order. Random idle bursts on both sides, one long
// output hold to back the block up, and a final stretch with no idling.
// ---------------------------------------------------------------------------
module tb_top;
  import tsmi_pkg::*;

  localparam int          MARKER_SLOTS = MAX_MARKERS_DEF;
  localparam longint      CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic        tag_hit;
    logic [7:0]  id;
    logic [15:0] ck;
    logic        ovf;
  } tag_result_t;

  // DUT inputs, known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [1:0]  func = '0;
  logic [31:0] marker_value = '0;
  logic        has_l4_checksum = 1'b0;
  logic [15:0] old_checksum = '0;
  logic        odd_length = 1'b0;
  logic        out_stall = 1'b0;

  // DUT outputs
  logic        cfg_ready;
  logic        in_stall;
  logic        out_valid;
  logic        tagged_res;
  logic [7:0]  tag_id;
  logic [15:0] new_checksum;
  logic        load_overflow;

  // local model of the tagger
  logic [31:0] mk_list [MARKER_SLOTS];
  int unsigned mk_fill = 0;
  int unsigned mk_pos = 0;
  logic [63:0] pkt_count = '0;
  logic [63:0] armed_at = '1;
  logic [7:0]  tag_seq = '0;
  logic [31:0] interval_q = '0;

  tag_result_t tag_results_due[$];
  tag_result_t want;
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  longint      cycle_count = 0;
  bit          bursts_on = 1'b1;
  bit          output_hold = 1'b0;
  int unsigned stall_left = 0;

  timestamp_tag_marker_insert uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .marker_value    (marker_value),
    .has_l4_checksum (has_l4_checksum),
    .old_checksum    (old_checksum),
    .odd_length      (odd_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .tagged_res      (tagged_res),
    .tag_id          (tag_id),
    .new_checksum    (new_checksum),
    .load_overflow   (load_overflow)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // RFC 1624 style update for the trailer words that carry the tag id
  function automatic logic [15:0] patch_checksum(logic [15:0] old, logic [7:0] id,
                                                 logic odd);
    logic [31:0] acc;
    if (odd)
      acc = {16'h0, ~old} + {16'h0, ~CK_ODD_OLD_HI} + {16'h0, CK_ODD_NEW_HI}
          + {16'h0, ~CK_ODD_LO} + {16'h0, CK_ODD_LO | {8'h0, id}};
    else
      acc = {16'h0, ~old} + {16'h0, ~CK_EVEN_OLD} + {16'h0, id, CK_EVEN_NEW_LO[7:0]};
    while (acc > 32'hffff)
      acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    return ~acc[15:0];
  endfunction

  // Advance the local model by one accepted transaction, return its result
  function automatic tag_result_t predict_tag(op_t op, logic [31:0] mval, logic hc,
                                              logic [15:0] oldck, logic odd);
    tag_result_t r;
    logic [31:0] step;
    r = '0;
    case (op)
      OP_CLEAR: begin
        mk_fill = 0;
        mk_pos  = 0;
      end
      OP_APPEND: begin
        if (mk_fill < MARKER_SLOTS) begin
          mk_list[mk_fill] = mval;
          mk_fill++;
        end else begin
          r.ovf = 1'b1;
        end
      end
      OP_START: begin
        mk_pos = 0;
        armed_at = pkt_count + ((mk_fill > 0) ? {32'h0, mk_list[0]} : 64'hffff_ffff_ffff_ffff);
      end
      default: begin
        r.ck = oldck;
        if (pkt_count == armed_at) begin
          r.tag_hit = 1'b1;
          r.id      = tag_seq;
          if (hc)
            r.ck = patch_checksum(oldck, tag_seq, odd);
          tag_seq++;
          if (mk_fill > 0 && mk_pos < mk_fill) begin
            // last delta closes the ring through the repeat interval
            if (mk_pos + 1 < mk_fill)
              step = mk_list[mk_pos + 1] - mk_list[mk_pos];
            else
              step = interval_q - mk_list[mk_fill - 1] + mk_list[0];
            armed_at += {32'h0, step};
            mk_pos++;
            if (mk_pos >= mk_fill)
              mk_pos = 0;
          end else begin
            // empty list: pushed out of reach
            armed_at += 64'hffff_ffff_ffff_ffff;
            mk_pos = 0;
          end
        end
        pkt_count++;
      end
    endcase
    return r;
  endfunction

  // Input side. Leaves in_valid high after acceptance; the next call (or
  // wait_idle) must come with no time elapsed so it owns the next negedge.
  task automatic send_item(op_t op, logic [31:0] mval, logic hc, logic [15:0] oldck,
                           logic odd);
    @(negedge clk);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    func            <= op;
    marker_value    <= mval;
    has_l4_checksum <= hc;
    old_checksum    <= oldck;
    odd_length      <= odd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tag_results_due.push_back(predict_tag(op, mval, hc, oldck, odd));
    items_sent++;
  endtask

  task automatic send_random_item();
    send_item(op_t'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
              16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_packet(logic hc, logic [15:0] oldck, logic odd);
    send_item(OP_PACKET, $urandom, hc, oldck, odd);
  endtask

  task automatic send_random_packet();
    send_packet(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                1'($urandom_range(0, 1)));
  endtask

  // Drop valid and drain every outstanding result; every transaction yields
  // one result, so an empty queue means the pipe is empty.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (tag_results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_interval(logic [31:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    interval_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Long output hold, counted here while the sender keeps offering
  task automatic hold_output(int unsigned cycles);
    @(posedge clk);
    output_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    output_hold = 1'b0;
  endtask

  // Output stall: long hold first, else random stall bursts
  always @(negedge clk) begin
    if (output_hold) begin
      out_stall <= 1'b1;
    end else if (bursts_on && stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_field(string field, longint unsigned got, longint unsigned exp_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on %s: expected %0h, got %0h", field, exp_v, got);
  endtask

  // Result checker: in-order compare against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (tag_results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result with nothing pending: tagged %0b id %0h ck %0h ovf %0b",
                   tagged_res, tag_id, new_checksum, load_overflow);
      end else begin
        want = tag_results_due.pop_front();
        if (tagged_res !== want.tag_hit)
          report_field("tagged_res", tagged_res, want.tag_hit);
        if (tag_id !== want.id)
          report_field("tag_id", tag_id, want.id);
        if (new_checksum !== want.ck)
          report_field("new_checksum", new_checksum, want.ck);
        if (load_overflow !== want.ovf)
          report_field("load_overflow", load_overflow, want.ovf);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timestamp_tag_marker_insert test failed");
      $finish;
    end
  end

  // Nothing armed after reset; a start on an empty list stays out of reach
  task automatic test_power_on_state();
    send_packet(1'b1, 16'hffff, 1'b0);
    send_item(OP_START, '0, 1'b0, '0, 1'b0);
    send_packet(1'b1, 16'h0000, 1'b1);
  endtask

  // One marker, interval 1: every packet tagged; both lengths, both extremes
  task automatic test_checksum_patch();
    write_interval(32'd1);
    send_item(OP_CLEAR, '0, 1'b0, '0, 1'b0);
    send_item(OP_APPEND, 32'd0, 1'b0, '0, 1'b0);
    send_item(OP_START, '0, 1'b0, '0, 1'b0);
    send_packet(1'b1, 16'h0000, 1'b0);
    send_packet(1'b1, 16'hffff, 1'b1);
    send_packet(1'b0, 16'h1234, 1'b1);
    send_packet(1'b1, 16'h0000, 1'b1);
    send_packet(1'b1, 16'hffff, 1'b0);
  endtask

  // Marker and interval extremes, including a wrapped closing delta
  task automatic test_marker_extremes();
    write_interval(32'hffff_ffff);
    send_item(OP_CLEAR, '0, 1'b0, '0, 1'b0);
    send_item(OP_APPEND, 32'hffff_ffff, 1'b1, 16'hffff, 1'b1);
    send_item(OP_START, 32'hffff_ffff, 1'b1, 16'hffff, 1'b1);
    send_packet(1'b1, 16'h8001, 1'b1);
    write_interval(32'd0);
    send_item(OP_CLEAR, '0, 1'b0, '0, 1'b0);
    send_item(OP_APPEND, 32'd0, 1'b0, '0, 1'b0);
    send_item(OP_APPEND, 32'd3, 1'b0, '0, 1'b0);
    send_item(OP_START, '0, 1'b0, '0, 1'b0);
    repeat (4) send_packet(1'b1, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  // Clear keeps the armed position; the hit then lands on an empty list
  task automatic test_clear_keeps_armed();
    send_item(OP_CLEAR, '0, 1'b0, '0, 1'b0);
    send_item(OP_APPEND, 32'd2, 1'b0, '0, 1'b0);
    send_item(OP_START, '0, 1'b0, '0, 1'b0);
    send_item(OP_CLEAR, '0, 1'b0, '0, 1'b0);
    repeat (4) send_packet(1'b1, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  // Fill the list, then appends past capacity are flagged and dropped
  task automatic test_list_full();
    send_item(OP_CLEAR, '0, 1'b0, '0, 1'b0);
    repeat (MARKER_SLOTS) send_item(OP_APPEND, $urandom, 1'b0, '0, 1'b0);
    send_item(OP_APPEND, 32'hffff_ffff, 1'b1, 16'hffff, 1'b1);
    send_item(OP_APPEND, 32'h0, 1'b0, 16'h0, 1'b0);
    send_item(OP_START, '0, 1'b0, '0, 1'b0);
    repeat (3) send_packet(1'b1, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  // Output held for a long stretch while packets keep coming
  task automatic test_backpressure();
    write_interval(32'd1);
    send_item(OP_CLEAR, '0, 1'b0, '0, 1'b0);
    send_item(OP_APPEND, 32'd0, 1'b0, '0, 1'b0);
    send_item(OP_START, '0, 1'b0, '0, 1'b0);
    fork
      hold_output(100);
      repeat (40) send_random_packet();
    join
  endtask

  // Mostly well-formed runs (interval, clear, load, start, packets) with
  // some noise mixed in, plus purely random stretches
  task automatic test_random_runs(int unsigned budget);
    int unsigned stop_at;
    int unsigned n_mk;
    logic [31:0] mark;
    logic [31:0] span;
    logic [31:0] run_marks[$];
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 4) != 0) begin
        n_mk = ($urandom_range(0, 7) == 0) ? $urandom_range(9, MARKER_SLOTS)
                                          : $urandom_range(1, 8);
        run_marks.delete();
        mark = $urandom_range(0, 3);
        for (int k = 0; k < n_mk; k++) begin
          run_marks.push_back(mark);
          mark += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        end
        case ($urandom_range(0, 7))
          0:       span = 32'd0;
          1:       span = 32'hffff_ffff;
          2:       span = $urandom;
          default: span = run_marks[$] - run_marks[0] + $urandom_range(1, 4);
        endcase
        write_interval(span);
        send_item(OP_CLEAR, $urandom, 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        foreach (run_marks[k])
          send_item(OP_APPEND, run_marks[k], 1'($urandom_range(0, 1)),
                    16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        send_item(OP_START, $urandom, 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(8, 40)) begin
          if ($urandom_range(0, 11) == 0)
            send_random_item();
          else
            send_random_packet();
        end
      end else begin
        repeat ($urandom_range(5, 15)) send_random_item();
      end
    end
  endtask

  // Last stretch, no idling: every packet tagged so the tag id wraps
  task automatic test_tag_wrap();
    bursts_on = 1'b0;
    write_interval(32'd1);
    send_item(OP_CLEAR, '0, 1'b0, '0, 1'b0);
    send_item(OP_APPEND, 32'd0, 1'b0, '0, 1'b0);
    send_item(OP_START, '0, 1'b0, '0, 1'b0);
    repeat (260) send_random_packet();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_power_on_state();
    test_checksum_patch();
    test_marker_extremes();
    test_clear_keeps_armed();
    test_list_full();
    test_backpressure();
    test_random_runs(200);
    test_tag_wrap();
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("timestamp_tag_marker_insert test passed");
    end else begin
      $display("timestamp_tag_marker_insert test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/tsmi_pkg.sv
hw/rtl/tsmi_front.sv
hw/rtl/tsmi_queue.sv
hw/rtl/tsmi_back.sv
hw/rtl/timestamp_tag_marker_insert.sv
sim/tb_top.sv
